/* rtl/core/bbc_pkg.sv */
// Package for the bracket balance checker: bracket kinds, verdict codes,
// character constants and the character classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int TALLY_W         = 16;
    localparam int VERDICT_W       = 3;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_CURLY  = 2'd1,
        KIND_SQUARE = 2'd2
    } t_kind;

    typedef enum logic [VERDICT_W-1:0] {
        V_BALANCED = 3'd0,
        V_MISMATCH = 3'd1,
        V_NO_OPEN  = 3'd2,
        V_UNCLOSED = 3'd3,
        V_OVERFLOW = 3'd4
    } t_verdict;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
    } t_class;

    function automatic t_class classify(input logic [7:0] ch);
        t_class c;
        c = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_ROUND};
        unique case (ch)
            CH_ROUND_OPEN: begin
                c.is_open = 1'b1;
                c.kind    = KIND_ROUND;
            end
            CH_CURLY_OPEN: begin
                c.is_open = 1'b1;
                c.kind    = KIND_CURLY;
            end
            CH_SQUARE_OPEN: begin
                c.is_open = 1'b1;
                c.kind    = KIND_SQUARE;
            end
            CH_ROUND_CLOSE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_ROUND;
            end
            CH_CURLY_CLOSE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_CURLY;
            end
            CH_SQUARE_CLOSE: begin
                c.is_close = 1'b1;
                c.kind     = KIND_SQUARE;
            end
            default: begin
                c.is_open = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/bbc_ifs.sv */
// Valid/ready channel interfaces of the bracket balance checker:
// character requests in, verdict results out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bbc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       is_final;

    modport source (output valid, output symbol, output is_final, input ready);
    modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

interface bbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  verdict;
    logic        no_brackets;
    logic [15:0] bracket_total;

    modport source (output valid, output verdict, output no_brackets,
                    output bracket_total, input ready);
    modport sink   (input valid, input verdict, input no_brackets,
                    input bracket_total, output ready);
endinterface

`default_nettype wire

/* rtl/core/bbc_cell.sv */
// One entry of the shifting bracket stack: takes its upper neighbor on a
// push and its lower neighbor on a pop. Depends on bbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbc_cell (
    input  wire              i_clk,
    input  wire              i_push,
    input  wire              i_pop,
    input  bbc_pkg::t_kind   i_from_above,
    input  bbc_pkg::t_kind   i_from_below,
    output bbc_pkg::t_kind   o_kind
);
    import bbc_pkg::*;

    t_kind r_kind;
    t_kind n_kind;

    always_comb begin
        if (i_push) begin
            n_kind = i_from_above;
        end else if (i_pop) begin
            n_kind = i_from_below;
        end else begin
            n_kind = r_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

    assign o_kind = r_kind;

endmodule

`default_nettype wire

/* rtl/core/bracket_balance_checker.sv */
// Top level of the bracket balance checker: control, level counter,
// error latch, tally and result register around a row of bbc_cell.
// Depends on bbc_pkg, bbc_ifs and bbc_cell.
//
//   channel  dir  payload                                  accepted when
//   i_req    in   symbol[7:0], is_final                    valid && ready
//   o_rsp    out  verdict[2:0], no_brackets, total[15:0]   valid && ready
//
// One request per cycle when ready; a final one gives a result next cycle.
// Cell 0 holds the stack top; a push or pop shifts the whole row at once.
// i_req.ready drops only while a result waits and o_rsp.ready is low.
// Synchronous reset clears level, error, tally and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);
    import bbc_pkg::*;

    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    logic [LVL_W-1:0]   r_level;
    logic [LVL_W-1:0]   n_level;
    t_verdict           r_err;
    t_verdict           n_err;
    logic [TALLY_W-1:0] r_tally;
    logic [TALLY_W-1:0] n_tally;

    logic               r_out_valid;
    t_verdict           r_verdict;
    logic               r_no_brackets;
    logic [TALLY_W-1:0] r_total;

    t_class             w_cls;
    logic               w_accept;
    logic               w_push;
    logic               w_pop;
    t_kind              w_kind [STACK_DEPTH];
    t_verdict           w_verdict;

    assign w_cls    = classify(i_req.symbol);
    assign w_accept = i_req.valid && i_req.ready;

    // advance the stack, the level, the tally and the error latch
    always_comb begin
        w_push  = 1'b0;
        w_pop   = 1'b0;
        n_err   = r_err;
        n_level = r_level;
        n_tally = r_tally;
        if (w_accept && (w_cls.is_open || w_cls.is_close)) begin
            if (r_tally != TALLY_MAX) begin
                n_tally = r_tally + TALLY_W'(1);
            end
            if (r_err == V_BALANCED) begin
                if (w_cls.is_open) begin
                    if (r_level == LVL_FULL) begin
                        n_err = V_OVERFLOW;
                    end else begin
                        w_push  = 1'b1;
                        n_level = r_level + LVL_ONE;
                    end
                end else if (r_level == '0) begin
                    n_err = V_NO_OPEN;
                end else if (w_kind[0] != w_cls.kind) begin
                    n_err = V_MISMATCH;
                end else begin
                    w_pop   = 1'b1;
                    n_level = r_level - LVL_ONE;
                end
            end
        end
    end

    always_comb begin
        if (n_err != V_BALANCED) begin
            w_verdict = n_err;
        end else if (n_level != '0) begin
            w_verdict = V_UNCLOSED;
        end else begin
            w_verdict = V_BALANCED;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            t_kind w_above;
            t_kind w_below;
            if (gi == 0) begin : g_top
                assign w_above = w_cls.kind;
            end else begin : g_mid
                assign w_above = w_kind[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_bottom
                assign w_below = w_kind[gi];
            end else begin : g_inner
                assign w_below = w_kind[gi+1];
            end
            bbc_cell u_cell (
                .i_clk        (i_clk),
                .i_push       (w_push),
                .i_pop        (w_pop),
                .i_from_above (w_above),
                .i_from_below (w_below),
                .o_kind       (w_kind[gi])
            );
        end
    endgenerate

    // update per-expression state, and clear it after the final request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_err   <= V_BALANCED;
            r_tally <= '0;
        end else if (w_accept && i_req.is_final) begin
            r_level <= '0;
            r_err   <= V_BALANCED;
            r_tally <= '0;
        end else begin
            r_level <= n_level;
            r_err   <= n_err;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_req.is_final) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.is_final) begin
            r_verdict     <= w_verdict;
            r_no_brackets <= (n_tally == '0);
            r_total       <= n_tally;
        end
    end

    assign i_req.ready         = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.verdict       = r_verdict;
    assign o_rsp.no_brackets   = r_no_brackets;
    assign o_rsp.bracket_total = r_total;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_FULL)
        else $error("stack level beyond depth");

    a_frozen_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != V_BALANCED && !(w_accept && i_req.is_final)) |=> $stable(r_level))
        else $error("stack moved after an error");

    a_final_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.is_final) |=> o_rsp.valid)
        else $error("final request gave no result");

    a_no_latched_unclosed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != V_UNCLOSED)
        else $error("unclosed latched as an error");

endmodule

`default_nettype wire
